### hw/rtl/ihex_pkg.sv
// shared types and constants of the intel hex record parser
package ihex_pkg;

  localparam int unsigned DEF_ADDRESS_BITS = 32;

  // result kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_CORRUPT  = 2'd0;
  localparam logic [1:0] ERR_CHECKSUM = 2'd1;
  localparam logic [1:0] ERR_TYPE     = 2'd2;
  localparam logic [1:0] ERR_EXTENDED = 2'd3;

  // record types
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_SEG = 8'h02;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  localparam logic [7:0] CHAR_COLON   = 8'h3a;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic        byte_lane;
    logic [1:0]  error_code;
  } out_word_t;

endpackage

### hw/rtl/intel_hex_record_parser_top.sv
// intel hex record parser, one text character per word
//
//  channel | direction | payload                        | handshake
//  --------+-----------+--------------------------------+-----------------------
//  in_     | input     | ihex_pkg::in_word_t            | in_valid / in_ready
//  out_    | output    | ihex_pkg::out_word_t           | out_valid / out_ready
//  cfg_    | input     | cfg_word_mode (1 bit)          | cfg_valid / cfg_ready
//
// one character is taken per cycle while in_ready is high; its result appears in
// the output register on the next cycle, and throughput is one word per cycle
// the output register is the only buffer: in_ready drops only while a result
// sits there and out_ready is low
// rst_n is synchronous; after reset the parser expects a ':' at line start
// after an end-of-file record or any error the block keeps taking words and
// drops them until the next reset
// cfg_ready is always high
module intel_hex_record_parser_top #(
  parameter int unsigned ADDRESS_BITS = ihex_pkg::DEF_ADDRESS_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  ihex_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ihex_pkg::out_word_t  out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_word_mode
);

  typedef enum logic [2:0] {
    PH_START, PH_LEN, PH_ADDR, PH_TYPE, PH_DATA, PH_EXT, PH_SUM, PH_TAIL
  } phase_t;

  // parser state
  phase_t                  phase_r, phase_nxt;
  logic [8:0]              dc_r, dc_nxt;
  logic [7:0]              rec_len_r, rec_len_nxt;
  logic [15:0]             rec_addr_r, rec_addr_nxt;
  logic [7:0]              rec_type_r, rec_type_nxt;
  logic [7:0]              sum_r, sum_nxt;
  logic [3:0]              hi_nib_r, hi_nib_nxt;
  logic [15:0]             ext_r, ext_nxt;
  logic [ADDRESS_BITS-1:0] base_r, base_nxt;
  logic                    halted_r, halted_nxt;
  logic                    word_mode_r;

  // output register
  logic                    out_valid_r;
  ihex_pkg::out_word_t     out_word_r;

  // result of the current character
  logic                    res_valid;
  ihex_pkg::out_word_t     res;

  logic                    in_acc;
  logic                    is_hex;
  logic [3:0]              nib;
  logic [7:0]              data_byte;
  logic [7:0]              chk_byte;
  logic [9:0]              dc_inc;
  logic [ADDRESS_BITS-1:0] full_addr;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // strict hex digit decode
  always_comb begin
    is_hex = 1'b1;
    nib    = 4'h0;
    if (in_word.character inside {[8'h30:8'h39]}) begin
      nib = 4'(in_word.character - 8'h30);
    end else if (in_word.character inside {[8'h41:8'h46]}) begin
      nib = 4'(in_word.character - 8'h37);
    end else if (in_word.character inside {[8'h61:8'h66]}) begin
      nib = 4'(in_word.character - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign data_byte = {hi_nib_r, nib};
  assign chk_byte  = 8'(sum_r + data_byte);
  assign dc_inc    = {1'b0, dc_r} + 10'd1;

  // base plus record address plus byte offset, wrapped at the address width
  assign full_addr = base_r + ADDRESS_BITS'(rec_addr_r) + ADDRESS_BITS'(dc_r[8:1]);

  // next state and result for one character
  always_comb begin
    phase_nxt    = phase_r;
    dc_nxt       = dc_r;
    rec_len_nxt  = rec_len_r;
    rec_addr_nxt = rec_addr_r;
    rec_type_nxt = rec_type_r;
    sum_nxt      = sum_r;
    hi_nib_nxt   = hi_nib_r;
    ext_nxt      = ext_r;
    base_nxt     = base_r;
    halted_nxt   = halted_r;
    res_valid    = 1'b0;
    res          = '0;

    if (!halted_r) begin
      if (in_word.end_of_input) begin
        // text ended before an end-of-file record
        res_valid      = 1'b1;
        res.kind       = ihex_pkg::KIND_ERROR;
        res.error_code = ihex_pkg::ERR_CORRUPT;
      end else if (phase_r == PH_START) begin
        if (in_word.character != ihex_pkg::CHAR_COLON) begin
          res_valid      = 1'b1;
          res.kind       = ihex_pkg::KIND_ERROR;
          res.error_code = ihex_pkg::ERR_CORRUPT;
        end else begin
          phase_nxt    = PH_LEN;
          dc_nxt       = '0;
          rec_len_nxt  = '0;
          rec_addr_nxt = '0;
          rec_type_nxt = '0;
          sum_nxt      = '0;
          ext_nxt      = '0;
          hi_nib_nxt   = '0;
        end
      end else if (phase_r == PH_TAIL) begin
        // skip everything up to the newline
        if (in_word.character == ihex_pkg::CHAR_NEWLINE) begin
          phase_nxt = PH_START;
        end
      end else if (!is_hex) begin
        // covers stray characters and short lines
        res_valid      = 1'b1;
        res.kind       = ihex_pkg::KIND_ERROR;
        res.error_code = ihex_pkg::ERR_CORRUPT;
      end else begin
        case (phase_r)
          PH_LEN: begin
            rec_len_nxt = {rec_len_r[3:0], nib};
            dc_nxt      = dc_inc[8:0];
            if (dc_r == 9'd1) begin
              sum_nxt   = 8'(sum_r + rec_len_nxt);
              phase_nxt = PH_ADDR;
              dc_nxt    = '0;
            end
          end
          PH_ADDR: begin
            rec_addr_nxt = {rec_addr_r[11:0], nib};
            dc_nxt       = dc_inc[8:0];
            if (dc_r == 9'd3) begin
              sum_nxt   = 8'(sum_r + rec_addr_nxt[15:8] + rec_addr_nxt[7:0]);
              phase_nxt = PH_TYPE;
              dc_nxt    = '0;
            end
          end
          PH_TYPE: begin
            rec_type_nxt = {rec_type_r[3:0], nib};
            dc_nxt       = dc_inc[8:0];
            if (dc_r == 9'd1) begin
              sum_nxt = 8'(sum_r + rec_type_nxt);
              dc_nxt  = '0;
              if (rec_type_nxt == ihex_pkg::REC_EOF) begin
                res_valid = 1'b1;
                res.kind  = ihex_pkg::KIND_EOF;
              end else if (rec_type_nxt inside {ihex_pkg::REC_EXT_SEG,
                                                ihex_pkg::REC_EXT_LIN}) begin
                if (rec_len_r != 8'd2 || rec_addr_r != 16'h0000) begin
                  res_valid      = 1'b1;
                  res.kind       = ihex_pkg::KIND_ERROR;
                  res.error_code = ihex_pkg::ERR_EXTENDED;
                end else begin
                  phase_nxt = PH_EXT;
                end
              end else if (rec_type_nxt != ihex_pkg::REC_DATA) begin
                res_valid      = 1'b1;
                res.kind       = ihex_pkg::KIND_ERROR;
                res.error_code = ihex_pkg::ERR_TYPE;
              end else begin
                phase_nxt = (rec_len_r != 8'd0) ? PH_DATA : PH_SUM;
              end
            end
          end
          PH_DATA: begin
            dc_nxt = dc_inc[8:0];
            if (!dc_r[0]) begin
              hi_nib_nxt = nib;
            end else begin
              sum_nxt        = 8'(sum_r + data_byte);
              res_valid      = 1'b1;
              res.kind       = ihex_pkg::KIND_WRITE;
              res.write_data = data_byte;
              if (word_mode_r) begin
                res.write_address = 32'(full_addr[ADDRESS_BITS-1:1]);
                res.byte_lane     = full_addr[0];
              end else begin
                res.write_address = 32'(full_addr);
              end
              if (dc_inc >= {1'b0, rec_len_r, 1'b0}) begin
                phase_nxt = PH_SUM;
                dc_nxt    = '0;
              end
            end
          end
          PH_EXT: begin
            ext_nxt = {ext_r[11:0], nib};
            dc_nxt  = dc_inc[8:0];
            if (dc_r == 9'd3) begin
              sum_nxt = 8'(sum_r + ext_nxt[15:8] + ext_nxt[7:0]);
              if (rec_type_r == ihex_pkg::REC_EXT_SEG) begin
                base_nxt = ADDRESS_BITS'({12'h000, ext_nxt, 4'h0});
              end else begin
                base_nxt = ADDRESS_BITS'({ext_nxt, 16'h0000});
              end
              phase_nxt = PH_SUM;
              dc_nxt    = '0;
            end
          end
          PH_SUM: begin
            if (dc_r == 9'd0) begin
              hi_nib_nxt = nib;
              dc_nxt     = 9'd1;
            end else begin
              dc_nxt = '0;
              if (chk_byte != 8'h00) begin
                res_valid      = 1'b1;
                res.kind       = ihex_pkg::KIND_ERROR;
                res.error_code = ihex_pkg::ERR_CHECKSUM;
              end else begin
                phase_nxt = PH_TAIL;
              end
            end
          end
          default: begin
            res_valid      = 1'b1;
            res.kind       = ihex_pkg::KIND_ERROR;
            res.error_code = ihex_pkg::ERR_CORRUPT;
          end
        endcase
      end
      // end-of-file and errors stop the parser
      if (res_valid && res.kind != ihex_pkg::KIND_WRITE) begin
        halted_nxt = 1'b1;
      end
    end
  end

  // state, config and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      dc_r        <= '0;
      rec_len_r   <= '0;
      rec_addr_r  <= '0;
      rec_type_r  <= '0;
      sum_r       <= '0;
      hi_nib_r    <= '0;
      ext_r       <= '0;
      base_r      <= '0;
      halted_r    <= 1'b0;
      word_mode_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        word_mode_r <= cfg_word_mode;
      end
      if (in_acc) begin
        phase_r    <= phase_nxt;
        dc_r       <= dc_nxt;
        rec_len_r  <= rec_len_nxt;
        rec_addr_r <= rec_addr_nxt;
        rec_type_r <= rec_type_nxt;
        sum_r      <= sum_nxt;
        hi_nib_r   <= hi_nib_nxt;
        ext_r      <= ext_nxt;
        base_r     <= base_nxt;
        halted_r   <= halted_nxt;
      end
      if (in_acc && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (in_acc && res_valid) begin
      out_word_r <= res;
    end
  end

  // once halted the parser stays halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("parser left halted state without reset");

  // a word taken while halted produces nothing
  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && halted_r) |=> !out_valid_r)
    else $error("result produced while halted");

  // end-of-file and error results halt the parser
  a_final_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res_valid && res.kind != ihex_pkg::KIND_WRITE) |=> halted_r)
    else $error("final result did not halt the parser");

  // data phase is only entered for a record with bytes
  a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (rec_len_r != 8'd0))
    else $error("data phase with zero record length");

endmodule
